// ===== rtl/core/lsad_pkg.sv =====
// Shared types and codes for the lane segment lookup block.
`default_nettype none

package lsad_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_WR_POINT = 2'd0;
  localparam logic [1:0] OP_WR_LANE  = 2'd1;
  localparam logic [1:0] OP_SEGMENT  = 2'd2;
  localparam logic [1:0] OP_LANE_LEN = 2'd3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_LANE_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HANDLE_TAG = 2'd1;

  // One input item.
  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         point_index;
    logic signed [31:0] point_progress;
    logic [7:0]         lane_index;
    logic [9:0]         lane_begin;
    logic [10:0]        lane_end;
    logic [15:0]        handle_tag;
    logic signed [31:0] distance;
  } lsad_in_t;

  // One result item.
  typedef struct packed {
    logic               ok;
    logic [9:0]         segment_index;
    logic signed [31:0] lane_length;
  } lsad_out_t;

  // One lane table entry.
  typedef struct packed {
    logic [9:0]  first_point;
    logic [10:0] end_point;
  } lsad_lane_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsad_point_mem.sv =====
// Point distance memory: one write port and one registered read port.
`default_nettype none

module lsad_point_mem import lsad_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [31:0]   wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [31:0]   rd_data
);

  logic signed [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lsad_lane_mem.sv =====
// Lane bounds memory: one write port and one registered read port.
`default_nettype none

module lsad_lane_mem import lsad_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  lsad_lane_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output lsad_lane_t    rd_data
);

  lsad_lane_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lane_segment_at_distance.sv =====
// Lane segment lookup: point and lane stores, and a search sequencer with one shared comparator.
// Writes and queries refused on tag or lane index answer in the cycle after the item is taken;
// refusals on the lane bounds answer from S_LANE, and a lane length query answers from S_LEN.
// A segment query is clamped to the first segment in S_FIRST or to the last in S_LAST, else
// halves its upper bound in S_SEARCH. One item at a time: the next is taken as its result shows.
// Reset clears the sequencer, the result strobe and both registers; the stores are not cleared.
`default_nettype none

module lane_segment_at_distance import lsad_pkg::*; #(
  parameter int POINT_DEPTH = 1024,
  parameter int LANE_DEPTH  = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  lsad_in_t               item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output lsad_out_t              result
);

  localparam int PAW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
  localparam int LAW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam logic [16:0] POINT_LIMIT = 17'(POINT_DEPTH);
  localparam logic [12:0] LANE_LIMIT  = 13'(LANE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LANE   = 6'b000010,
    S_FIRST  = 6'b000100,
    S_LAST   = 6'b001000,
    S_SEARCH = 6'b010000,
    S_LEN    = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [8:0]         lane_count;
  logic [15:0]        data_handle_tag;
  logic [1:0]         req_op;
  logic signed [31:0] req_dist;
  logic [9:0]         lane_b, lane_b_next;
  logic [10:0]        lane_e, lane_e_next;
  logic [10:0]        lane_n, lane_n_next;
  logic [10:0]        lo_pos, lo_pos_next;
  logic [10:0]        span, span_next;
  logic               done_next;
  lsad_out_t          result_next;

  logic               accept;
  logic               pt_wr_ok, lane_wr_ok, query_ok;
  logic               pt_rd_en;
  logic [11:0]        pt_rd_idx;
  logic signed [31:0] pt_rd_data;
  logic               lane_rd_en;
  lsad_lane_t         lane_wr_data, lane_rd_data;

  logic               cmp_lt, cmp_eq;
  logic [10:0]        half, probe, srch_lo, kk, kc, n_minus2;
  logic [11:0]        srch_addr, seg_sum;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Address range and handle checks on the incoming item.
  assign pt_wr_ok   = ({7'd0, item.point_index} < POINT_LIMIT);
  assign lane_wr_ok = ({5'd0, item.lane_index} < LANE_LIMIT);
  assign query_ok   = (item.handle_tag == data_handle_tag) &&
                      ({1'b0, item.lane_index} < lane_count) && lane_wr_ok;

  assign lane_wr_data.first_point = item.lane_begin;
  assign lane_wr_data.end_point   = item.lane_end;
  assign lane_rd_en = accept && (item.op != OP_WR_POINT) && (item.op != OP_WR_LANE) &&
                      query_ok;

  lsad_point_mem #(.DEPTH(POINT_DEPTH), .AW(PAW)) u_point_mem (
    .clk     (clk),
    .wr_en   (accept && (item.op == OP_WR_POINT) && pt_wr_ok),
    .wr_addr (PAW'(item.point_index)),
    .wr_data (item.point_progress),
    .rd_en   (pt_rd_en),
    .rd_addr (PAW'(pt_rd_idx)),
    .rd_data (pt_rd_data)
  );

  lsad_lane_mem #(.DEPTH(LANE_DEPTH), .AW(LAW)) u_lane_mem (
    .clk     (clk),
    .wr_en   (accept && (item.op == OP_WR_LANE) && lane_wr_ok),
    .wr_addr (LAW'(item.lane_index)),
    .wr_data (lane_wr_data),
    .rd_en   (lane_rd_en),
    .rd_addr (LAW'(item.lane_index)),
    .rd_data (lane_rd_data)
  );

  // The one shared signed comparator: query distance against the point just read.
  assign cmp_lt = (req_dist < pt_rd_data);
  assign cmp_eq = (req_dist == pt_rd_data);

  // One upper-bound halving step and the address of the next probe.
  assign half      = {1'b0, span[10:1]};
  assign probe     = lo_pos + half;
  assign srch_lo   = cmp_lt ? lo_pos : (probe + {10'd0, span[0]});
  assign srch_addr = {2'b00, lane_b} + {1'b0, srch_lo} + {2'b00, half[10:1]};

  // Upper bound minus one, clamped to the last segment, made global.
  assign n_minus2 = lane_n - 11'd2;
  assign kk       = (srch_lo == 11'd0) ? 11'd0 : (srch_lo - 11'd1);
  assign kc       = (kk > n_minus2) ? n_minus2 : kk;
  assign seg_sum  = {2'b00, lane_b} + {1'b0, kc};

  // Sequencer.
  always_comb begin
    state_next  = state;
    lane_b_next = lane_b;
    lane_e_next = lane_e;
    lane_n_next = lane_n;
    lo_pos_next = lo_pos;
    span_next   = span;
    done_next   = 1'b0;
    result_next = '0;
    pt_rd_en    = 1'b0;
    pt_rd_idx   = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.op)
            OP_WR_POINT: begin
              done_next      = 1'b1;
              result_next.ok = pt_wr_ok;
            end
            OP_WR_LANE: begin
              done_next      = 1'b1;
              result_next.ok = lane_wr_ok;
            end
            default: begin
              if (query_ok) begin
                state_next = S_LANE;
              end else begin
                done_next = 1'b1;
              end
            end
          endcase
        end
      end
      S_LANE: begin
        lane_b_next = lane_rd_data.first_point;
        lane_e_next = lane_rd_data.end_point;
        lane_n_next = lane_rd_data.end_point - {1'b0, lane_rd_data.first_point};
        state_next  = S_IDLE;
        if ({6'd0, lane_rd_data.end_point} > POINT_LIMIT) begin
          done_next = 1'b1;
        end else if (req_op == OP_LANE_LEN) begin
          if (lane_rd_data.end_point != 11'd0) begin
            pt_rd_en   = 1'b1;
            pt_rd_idx  = {1'b0, lane_rd_data.end_point - 11'd1};
            state_next = S_LEN;
          end else begin
            done_next = 1'b1;
          end
        end else if ({1'b0, lane_rd_data.end_point} >=
                     ({2'b00, lane_rd_data.first_point} + 12'd2)) begin
          pt_rd_en   = 1'b1;
          pt_rd_idx  = {2'b00, lane_rd_data.first_point};
          state_next = S_FIRST;
        end else begin
          done_next = 1'b1;
        end
      end
      S_FIRST: begin
        if (cmp_lt || cmp_eq) begin
          done_next                 = 1'b1;
          result_next.ok            = 1'b1;
          result_next.segment_index = lane_b;
          state_next                = S_IDLE;
        end else begin
          pt_rd_en   = 1'b1;
          pt_rd_idx  = {1'b0, lane_e - 11'd1};
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (!cmp_lt) begin
          done_next                 = 1'b1;
          result_next.ok            = 1'b1;
          result_next.segment_index = 10'(lane_e - 11'd2);
          state_next                = S_IDLE;
        end else begin
          lo_pos_next = '0;
          span_next   = lane_n;
          pt_rd_en    = 1'b1;
          pt_rd_idx   = {2'b00, lane_b} + {2'b00, lane_n[10:1]};
          state_next  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        lo_pos_next = srch_lo;
        span_next   = half;
        if (half == 11'd0) begin
          done_next                 = 1'b1;
          result_next.ok            = 1'b1;
          result_next.segment_index = seg_sum[9:0];
          state_next                = S_IDLE;
        end else begin
          pt_rd_en  = 1'b1;
          pt_rd_idx = srch_addr;
        end
      end
      S_LEN: begin
        done_next               = 1'b1;
        result_next.ok          = 1'b1;
        result_next.lane_length = pt_rd_data;
        state_next              = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      lane_count      <= '0;
      data_handle_tag <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LANE_COUNT: lane_count      <= cfg_data[8:0];
          CFG_HANDLE_TAG: data_handle_tag <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Item and search payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= item.op;
      req_dist <= item.distance;
    end
    lane_b <= lane_b_next;
    lane_e <= lane_e_next;
    lane_n <= lane_n_next;
    lo_pos <= lo_pos_next;
    span   <= span_next;
    result <= result_next;
  end

endmodule

`default_nettype wire

// ===== tb/sv/lane_lookup_checker.sv =====
// Checker for the lane segment lookup block: predicts each answer and compares it on arrival.
module lane_lookup_checker import lsad_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  lsad_in_t               item,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   done,
  input  lsad_out_t              result,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int POINT_SLOTS = 1024;
  localparam int LANE_SLOTS  = 256;

  // Private copy of the point and lane stores and of both registers.
  logic signed [31:0] progress_mem [POINT_SLOTS];
  logic [9:0]         lane_first   [LANE_SLOTS];
  logic [10:0]        lane_stop    [LANE_SLOTS];
  logic [8:0]         lanes_enabled;
  logic [15:0]        current_tag;

  // Answers owed by the block, oldest first.
  lsad_out_t owed_answers [$];
  lsad_out_t answer_now;

  // Last segment whose first point is at or below d, else the first; searched by halving.
  function automatic logic [9:0] segment_for(int unsigned b, int unsigned e,
                                             logic signed [31:0] d);
    int unsigned points, lo, span, odd, probe, k;
    points = e - b;
    if (d <= progress_mem[b]) return 10'(b);
    if (d >= progress_mem[e - 1]) return 10'(e - 2);
    lo = 0;
    span = points;
    while (span > 0) begin
      odd = span & 1;
      span = span >> 1;
      probe = lo + span;
      if (!(d < progress_mem[b + probe])) lo = probe + odd;
    end
    k = (lo == 0) ? 0 : lo - 1;
    if (k > points - 2) k = points - 2;
    return 10'(k + b);
  endfunction

  // Answer to a segment or length query against the current stores.
  function automatic lsad_out_t answer_query(lsad_in_t it);
    lsad_out_t r;
    int unsigned b, e;
    r = '0;
    b = lane_first[it.lane_index];
    e = lane_stop[it.lane_index];
    if (it.handle_tag == current_tag && it.lane_index < lanes_enabled && e <= POINT_SLOTS) begin
      if (it.op == OP_SEGMENT) begin
        if (e >= b + 2) begin
          r.ok = 1'b1;
          r.segment_index = segment_for(b, e, it.distance);
        end
      end else if (e >= 1) begin
        r.ok = 1'b1;
        r.lane_length = progress_mem[e - 1];
      end
    end
    return r;
  endfunction

  task automatic report(string field, longint want, longint got);
    mismatches = mismatches + 1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lanes_enabled = '0;
      current_tag = '0;
      owed_answers.delete();
    end else begin
      // Register writes are to be made only while the block is idle; the block itself does not enforce it.
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_LANE_COUNT: lanes_enabled = cfg_data[8:0];
          CFG_HANDLE_TAG: current_tag = cfg_data;
          default: ;
        endcase
      end

      // A result at this edge always belongs to an earlier item.
      if (done === 1'b1) begin
        if (owed_answers.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected result, expected none, actual ok=%0d seg=%0d len=%0d",
                   $time, result.ok, result.segment_index, result.lane_length);
        end else begin
          answer_now = owed_answers.pop_front();
          if (result.ok !== answer_now.ok)
            report("ok", answer_now.ok, result.ok);
          if (result.segment_index !== answer_now.segment_index)
            report("segment_index", answer_now.segment_index, result.segment_index);
          if (result.lane_length !== answer_now.lane_length)
            report("lane_length", answer_now.lane_length, result.lane_length);
        end
      end

      // Apply an accepted item to the private stores and queue its answer.
      if (start === 1'b1 && busy === 1'b0) begin
        answer_now = '0;
        case (item.op)
          OP_WR_POINT: begin
            progress_mem[item.point_index] = item.point_progress;
            answer_now.ok = 1'b1;
          end
          OP_WR_LANE: begin
            lane_first[item.lane_index] = item.lane_begin;
            lane_stop[item.lane_index] = item.lane_end;
            answer_now.ok = 1'b1;
          end
          default: answer_now = answer_query(item);
        endcase
        owed_answers.push_back(answer_now);
      end
    end
    outstanding <= owed_answers.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the lane segment lookup testbench: clock, reset, item and register traffic, verdict.
module tb_top;
  import lsad_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DIST_MIN   = 32'sh8000_0000;
  localparam int DIST_MAX   = 32'sh7FFF_FFFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  lsad_in_t               item = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   done;
  lsad_out_t              result;
  int                     mismatches;
  int                     outstanding;
  int                     quiet_cycles = 0;

  // What has been written so far, so that no query touches an unwritten entry.
  bit          point_set   [1024];
  int          point_value [1024];
  bit          lane_set    [256];
  int          lane_lo     [256];
  int          lane_hi     [256];
  int          lane_limit = 0;
  logic [15:0] tag_now = '0;
  int          sent = 0;
  bit          steady = 1'b0;

  lane_segment_at_distance DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  lane_lookup_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles in which no item, result or register write moves.
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, a few long ones, none at all during steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lsad_in_t raw_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return lsad_in_t'(bits[$bits(lsad_in_t)-1:0]);
  endfunction

  function automatic lsad_in_t point_write(int idx, int val);
    lsad_in_t it;
    it = raw_item();
    it.op = OP_WR_POINT;
    it.point_index = 10'(idx);
    it.point_progress = val;
    return it;
  endfunction

  function automatic lsad_in_t lane_write(int lane, int b, int e);
    lsad_in_t it;
    it = raw_item();
    it.op = OP_WR_LANE;
    it.lane_index = 8'(lane);
    it.lane_begin = 10'(b);
    it.lane_end = 11'(e);
    return it;
  endfunction

  function automatic lsad_in_t lane_query(logic [1:0] op, int lane, logic [15:0] tag, int d);
    lsad_in_t it;
    it = raw_item();
    it.op = op;
    it.lane_index = 8'(lane);
    it.handle_tag = tag;
    it.distance = d;
    return it;
  endfunction

  // True when the item reads only store entries that were written before.
  function automatic bit reads_safe(lsad_in_t it);
    int b, e;
    if (it.op == OP_WR_POINT || it.op == OP_WR_LANE) return 1'b1;
    if (it.handle_tag != tag_now || it.lane_index >= lane_limit) return 1'b1;
    if (!lane_set[it.lane_index]) return 1'b0;
    b = lane_lo[it.lane_index];
    e = lane_hi[it.lane_index];
    if (e > 1024) return 1'b1;
    if (it.op == OP_LANE_LEN) return (e == 0) || point_set[e - 1];
    if (e < b + 2) return 1'b1;
    for (int i = b; i < e; i++) begin
      if (!point_set[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_lane();
    if (lane_limit > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, lane_limit - 1);
    return $urandom_range(0, 255);
  endfunction

  // Distances near the stored points of a lane, past its ends, or anywhere.
  function automatic int probe_distance(int b, int e);
    int i, r;
    if (e > 1024 || e <= b) return $urandom;
    i = $urandom_range(b, e - 1);
    r = $urandom_range(0, 99);
    if (r < 35) return point_value[i];
    if (r < 55) return point_value[i] + ($urandom_range(0, 1) ? 1 : -1);
    if (r < 65) return point_value[b] - $urandom_range(0, 255);
    if (r < 75) return point_value[e - 1] + $urandom_range(0, 255);
    if (r < 80) return DIST_MIN;
    if (r < 85) return DIST_MAX;
    return $urandom;
  endfunction

  // Offer one item, hold it until taken, then idle for the given gap.
  task automatic send(input lsad_in_t it, input int gap);
    if (!reads_safe(it)) it.handle_tag = tag_now ^ 16'($urandom_range(1, 65535));
    if (it.op == OP_WR_POINT) begin
      point_set[it.point_index] = 1'b1;
      point_value[it.point_index] = it.point_progress;
    end else if (it.op == OP_WR_LANE) begin
      lane_set[it.lane_index] = 1'b1;
      lane_lo[it.lane_index] = it.lane_begin;
      lane_hi[it.lane_index] = it.lane_end;
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering items and wait until every answer has come back.
  task automatic settle();
    if (start) start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_config(int lanes, int tag);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LANE_COUNT;
    cfg_data <= 16'(lanes);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_index <= CFG_HANDLE_TAG;
    cfg_data <= 16'(tag);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    lane_limit = lanes;
    tag_now = 16'(tag);
  endtask

  // A few queries on one lane, mostly with the current tag.
  task automatic query_lane(int lane, int count);
    logic [1:0]  op;
    logic [15:0] tag;
    int          d;
    for (int q = 0; q < count; q++) begin
      op = ($urandom_range(0, 99) < 75) ? OP_SEGMENT : OP_LANE_LEN;
      tag = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) : tag_now;
      d = lane_set[lane] ? probe_distance(lane_lo[lane], lane_hi[lane]) : $urandom;
      send(lane_query(op, lane, tag, d), pick_gap());
    end
  endtask

  // Fill a run of points, mostly in rising order, map a lane onto it and query it.
  task automatic build_lane();
    int     n, b, r, lane, stride;
    longint level;
    bit     jumbled;
    r = $urandom_range(0, 99);
    if (r < 75) n = $urandom_range(2, 8);
    else if (r < 95) n = $urandom_range(9, 32);
    else n = $urandom_range(33, 120);
    b = $urandom_range(0, 1024 - n);
    jumbled = ($urandom_range(0, 9) == 0);
    stride = 1 << $urandom_range(0, 24);
    if ($urandom_range(0, 3) == 0) level = longint'($signed($urandom));
    else level = longint'($urandom_range(0, 1 << 20)) - 524288;
    for (int i = 0; i < n; i++) begin
      send(point_write(b + i, jumbled ? int'($urandom) : int'(level)), pick_gap());
      level += $urandom_range(0, stride);
      if (level > 64'sd2147483647) level = 64'sd2147483647;
    end
    lane = pick_lane();
    send(lane_write(lane, b, b + n), pick_gap());
    query_lane(lane, $urandom_range(2, 6));
  endtask

  // Lay a lane over points already written, often a long run of them, else build a new one.
  task automatic reuse_points();
    int b, e, run_end, lane;
    b = $urandom_range(0, 1022);
    if (!point_set[b]) begin
      build_lane();
      return;
    end
    run_end = b;
    while (run_end < 1024 && point_set[run_end]) run_end++;
    e = $urandom_range(0, 1) ? run_end : $urandom_range(b + 1, run_end);
    lane = pick_lane();
    send(lane_write(lane, b, e), pick_gap());
    query_lane(lane, $urandom_range(2, 6));
  endtask

  task automatic run_phase(int lanes, int tag, int quota);
    int       target, halfway, r;
    bit       drained;
    lsad_in_t stray;
    write_config(lanes, tag);
    target = sent + quota;
    halfway = sent + quota / 2;
    drained = 1'b0;
    while (sent < target) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        build_lane();
      end else if (r < 68) begin
        reuse_points();
      end else if (r < 85) begin
        for (int q = $urandom_range(3, 8); q > 0; q--) query_lane(pick_lane(), 1);
      end else begin
        // Stray item with random fields, lane bounds mostly inside the point memory.
        stray = raw_item();
        if (stray.op == OP_WR_LANE && $urandom_range(0, 7) != 0)
          stray.lane_end = 11'($urandom_range(0, 1024));
        if (stray.op >= OP_SEGMENT && $urandom_range(0, 1)) stray.handle_tag = tag_now;
        send(stray, pick_gap());
      end
      // Let the block run dry once in the middle of each phase.
      if (!drained && sent >= halfway) begin
        settle();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, every operation and each rejection path.
    write_config(0, 0);
    send(point_write(0, DIST_MIN), pick_gap());
    send(point_write(1, 0), pick_gap());
    send(point_write(2, DIST_MAX), pick_gap());
    send(point_write(1023, 32'h5A5A_A5A5), pick_gap());
    send(lane_write(0, 0, 3), pick_gap());
    // No lane is enabled yet, so this query is refused.
    send(lane_query(OP_SEGMENT, 0, 16'h0000, 1), pick_gap());

    write_config(256, 16'hFFFF);
    send(lane_query(OP_SEGMENT, 0, 16'hFFFF, DIST_MIN), pick_gap());
    send(lane_query(OP_SEGMENT, 0, 16'hFFFF, DIST_MAX), pick_gap());
    send(lane_query(OP_SEGMENT, 0, 16'hFFFF, 1), pick_gap());
    send(lane_query(OP_SEGMENT, 0, 16'h0000, 1), pick_gap());
    send(lane_query(OP_LANE_LEN, 0, 16'hFFFF, 0), pick_gap());
    // Single point lane: no segment, but a length.
    send(lane_write(255, 1023, 1024), pick_gap());
    send(lane_query(OP_SEGMENT, 255, 16'hFFFF, 7), pick_gap());
    send(lane_query(OP_LANE_LEN, 255, 16'hFFFF, 0), pick_gap());
    // End below begin.
    send(lane_write(1, 5, 3), pick_gap());
    send(lane_query(OP_SEGMENT, 1, 16'hFFFF, 0), pick_gap());
    // Empty lane has no length.
    send(lane_write(2, 0, 0), pick_gap());
    send(lane_query(OP_LANE_LEN, 2, 16'hFFFF, 0), pick_gap());
    // Lane reaching past the point memory.
    send(lane_write(3, 1, 2047), pick_gap());
    send(lane_query(OP_SEGMENT, 3, 16'hFFFF, 0), pick_gap());
    // Query over distances that are not in rising order, answered by the clamp to the last segment.
    send(point_write(3, -100), pick_gap());
    send(lane_write(4, 0, 4), pick_gap());
    send(lane_query(OP_SEGMENT, 4, 16'hFFFF, 5), pick_gap());

    // Random part over several register settings, the extremes among them.
    run_phase(256, $urandom_range(0, 65535), 380);
    run_phase($urandom_range(1, 255), $urandom_range(0, 65535), 300);
    run_phase(256, 0, 300);
    run_phase(0, 16'hFFFF, 40);
    run_phase(1, $urandom_range(0, 65535), 120);
    run_phase(256, $urandom_range(0, 65535), 380);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
